/* rtl/cpsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpsc_pkg;

  // Item operations carried in the op field.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_PULSE = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_OVERLOAD_GAP   = 3'd0,
    REG_OVERLOAD_LIMIT = 3'd1,
    REG_FULL_GAP       = 3'd2,
    REG_FULL_LIMIT     = 3'd3,
    REG_ENERGY_PER_COIN = 3'd4,
    REG_TIME_PER_COIN  = 3'd5,
    REG_REPORT_EVERY   = 3'd6
  } reg_idx_e;

  // Report kinds.
  localparam logic [1:0] RPT_NONE     = 2'd0;
  localparam logic [1:0] RPT_PROGRESS = 2'd1;
  localparam logic [1:0] RPT_FINAL    = 2'd2;

  // Stop reasons.
  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_TIMEOUT = 2'd1;
  localparam logic [1:0] STOP_ENERGY  = 2'd2;
  localparam logic [1:0] STOP_CMD     = 2'd3;

  // Declared conditions.
  localparam logic [1:0] COND_NONE     = 2'd0;
  localparam logic [1:0] COND_OVERLOAD = 2'd1;
  localparam logic [1:0] COND_FULL     = 2'd2;

  // Configuration register values after reset.
  localparam logic [15:0] OVERLOAD_GAP_RST    = 16'd100;
  localparam logic [7:0]  OVERLOAD_LIMIT_RST  = 8'd3;
  localparam logic [31:0] FULL_GAP_RST        = 32'd60000;
  localparam logic [7:0]  FULL_LIMIT_RST      = 8'd3;
  localparam logic [15:0] ENERGY_PER_COIN_RST = 16'd100;
  localparam logic [23:0] TIME_PER_COIN_RST   = 24'd3600000;
  localparam logic [7:0]  REPORT_EVERY_RST    = 8'd10;

  // Current configuration as seen by the session logic.
  typedef struct packed {
    logic [15:0] overload_gap_ms;
    logic [7:0]  overload_limit;
    logic [31:0] full_gap_ms;
    logic [7:0]  full_limit;
    logic [15:0] energy_per_coin;
    logic [23:0] time_per_coin_ms;
    logic [7:0]  report_every;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/cpsc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface cpsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       session_type;
  logic [7:0] coins;

  modport source (output valid, output op, output session_type, output coins, input ready);
  modport sink (input valid, input op, input session_type, input coins, output ready);
endinterface

// Result item channel.
interface cpsc_out_if;
  logic        valid;
  logic        ready;
  logic        relay_on;
  logic [1:0]  report_kind;
  logic [23:0] consumed;
  logic [1:0]  stop_reason;
  logic [1:0]  condition;

  modport source (output valid, output relay_on, output report_kind, output consumed,
                  output stop_reason, output condition, input ready);
  modport sink (input valid, input relay_on, input report_kind, input consumed,
                input stop_reason, input condition, output ready);
endinterface

// Configuration write channel.
interface cpsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/cpsc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpsc_cfg_regs (
  input  wire            clk_i,
  input  wire            rst_ni,
  cpsc_cfg_if.sink       cfg_i,
  output cpsc_pkg::cfg_t cfg_o
);
  import cpsc_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  // Writes are always taken; an index beyond the register list is dropped.
  assign cfg_i.ready = 1'b1;
  assign wr_en = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overload_gap_ms  <= OVERLOAD_GAP_RST;
      cfg_q.overload_limit   <= OVERLOAD_LIMIT_RST;
      cfg_q.full_gap_ms      <= FULL_GAP_RST;
      cfg_q.full_limit       <= FULL_LIMIT_RST;
      cfg_q.energy_per_coin  <= ENERGY_PER_COIN_RST;
      cfg_q.time_per_coin_ms <= TIME_PER_COIN_RST;
      cfg_q.report_every     <= REPORT_EVERY_RST;
    end else if (wr_en) begin
      case (cfg_i.index)
        REG_OVERLOAD_GAP:    cfg_q.overload_gap_ms  <= cfg_i.data[15:0];
        REG_OVERLOAD_LIMIT:  cfg_q.overload_limit   <= cfg_i.data[7:0];
        REG_FULL_GAP:        cfg_q.full_gap_ms      <= cfg_i.data;
        REG_FULL_LIMIT:      cfg_q.full_limit       <= cfg_i.data[7:0];
        REG_ENERGY_PER_COIN: cfg_q.energy_per_coin  <= cfg_i.data[15:0];
        REG_TIME_PER_COIN:   cfg_q.time_per_coin_ms <= cfg_i.data[23:0];
        REG_REPORT_EVERY:    cfg_q.report_every     <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/charge_port_session_controller.sv */
// Charge port session controller. Each transaction on the input channel (start,
// stop, energy pulse or millisecond tick) yields exactly one result transaction.
// An accepted item lands in an input register. Once the result register is free,
// the session logic evaluates it against the session state and loads the result
// register, which offers it as a result transaction on the output channel itself.
// With the output ready, one item can be accepted every cycle.
// Throughput is set by the single session-update stage. While a result waits for
// the output ready, the input register takes at most one more item. After that the
// input stalls until the result is taken. Configuration writes are accepted at any
// time but must only be issued while no item is in flight; they take effect on the
// next item.
`timescale 1ns / 1ps
`default_nettype none

module charge_port_session_controller #(
  parameter int TIME_BITS   = 32,
  parameter int ENERGY_BITS = 24
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cpsc_in_if.sink    in_i,
  cpsc_out_if.source out_o,
  cpsc_cfg_if.sink   cfg_i
);
  import cpsc_pkg::*;

  // Widths used to compare against the fixed-width registers.
  localparam int TW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int EW = (ENERGY_BITS > 24) ? ENERGY_BITS : 24;

  cfg_t cfg;

  cpsc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register.
  logic       in_valid_q;
  logic [1:0] op_q;
  logic       type_q;
  logic [7:0] coins_q;

  // Session state.
  logic                   active_q, active_d;
  logic                   online_q, online_d;
  logic [7:0]             budget_q, budget_d;
  logic [ENERGY_BITS-1:0] pulse_q, pulse_d;
  logic [7:0]             ovl_run_q, ovl_run_d;
  logic [7:0]             full_run_q, full_run_d;
  logic [7:0]             rpt_run_q, rpt_run_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  logic [TIME_BITS-1:0]   last_q, last_d;
  logic [TIME_BITS-1:0]   left_q, left_d;

  // Result register.
  logic        out_valid_q;
  logic        relay_q;
  logic [1:0]  kind_q, kind_d;
  logic [23:0] consumed_q, consumed_d;
  logic [1:0]  reason_q, reason_d;
  logic [1:0]  cond_q, cond_d;

  logic out_free;
  logic advance;

  // Handshake: the input register moves on whenever the result register is free.
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q    <= in_i.op;
      type_q  <= in_i.session_type;
      coins_q <= in_i.coins;
    end
  end

  // Arithmetic for the item in the input register.
  logic [31:0]          time_prod;
  logic [TW-1:0]        time_prod_ext;
  logic [TIME_BITS-1:0] time_budget;
  logic [23:0]          energy_limit;
  logic [TIME_BITS-1:0] gap;
  logic                 gap_short;
  logic                 gap_long;
  logic [ENERGY_BITS-1:0] pulse_inc;
  logic [EW-1:0]        pulse_inc_ext;
  logic [EW-1:0]        pulse_out_ext;
  logic [7:0]           ovl_next;
  logic [7:0]           full_next;
  logic [7:0]           rpt_next;

  assign time_prod     = 32'(coins_q) * 32'(cfg.time_per_coin_ms);
  assign time_prod_ext = TW'(time_prod);
  // The budget saturates at the largest time value.
  assign time_budget   = ((time_prod_ext >> TIME_BITS) != '0) ? '1
                         : time_prod_ext[TIME_BITS-1:0];
  assign energy_limit  = 24'(budget_q) * 24'(cfg.energy_per_coin);

  assign gap       = now_q - last_q;
  assign gap_short = gap < TIME_BITS'(cfg.overload_gap_ms);
  assign gap_long  = TW'(gap) > TW'(cfg.full_gap_ms);

  // Consumption saturates at the counter maximum.
  assign pulse_inc     = (pulse_q == '1) ? pulse_q : pulse_q + ENERGY_BITS'(1);
  assign pulse_inc_ext = EW'(pulse_inc);
  assign pulse_out_ext = EW'(pulse_q);

  assign ovl_next  = ovl_run_q + 8'd1;
  assign full_next = full_run_q + 8'd1;
  assign rpt_next  = rpt_run_q + 8'd1;

  // Session update and result for one item.
  always_comb begin
    active_d   = active_q;
    online_d   = online_q;
    budget_d   = budget_q;
    pulse_d    = pulse_q;
    ovl_run_d  = ovl_run_q;
    full_run_d = full_run_q;
    rpt_run_d  = rpt_run_q;
    now_d      = now_q;
    last_d     = last_q;
    left_d     = left_q;
    kind_d     = RPT_NONE;
    consumed_d = '0;
    reason_d   = STOP_NONE;
    cond_d     = COND_NONE;

    case (op_q)
      OP_START: begin
        active_d = 1'b1;
        online_d = type_q;
        budget_d = coins_q;
        pulse_d  = '0;
        left_d   = time_budget;
      end
      OP_STOP: begin
        if (active_q) begin
          consumed_d = pulse_out_ext[23:0];
          reason_d   = STOP_CMD;
          if (online_q) begin
            kind_d = RPT_FINAL;
          end
          active_d = 1'b0;
          online_d = 1'b0;
          budget_d = '0;
          pulse_d  = '0;
          left_d   = '0;
        end
      end
      OP_PULSE: begin
        if (active_q) begin
          pulse_d = pulse_inc;
          // Gap classification toward overload or battery full.
          if (gap_short) begin
            if (ovl_next > cfg.overload_limit) begin
              cond_d    = COND_OVERLOAD;
              ovl_run_d = '0;
            end else begin
              ovl_run_d = ovl_next;
            end
          end else if (gap_long) begin
            if (full_next > cfg.full_limit) begin
              cond_d     = COND_FULL;
              full_run_d = '0;
            end else begin
              full_run_d = full_next;
            end
          end else begin
            ovl_run_d  = '0;
            full_run_d = '0;
          end
          last_d     = now_q;
          consumed_d = pulse_inc_ext[23:0];
          if (!online_q) begin
            if (pulse_inc_ext >= EW'(energy_limit)) begin
              reason_d = STOP_ENERGY;
              active_d = 1'b0;
              online_d = 1'b0;
              budget_d = '0;
              pulse_d  = '0;
              left_d   = '0;
            end
          end else begin
            if (rpt_next >= cfg.report_every) begin
              rpt_run_d = '0;
              kind_d    = RPT_PROGRESS;
            end else begin
              rpt_run_d = rpt_next;
            end
          end
        end
      end
      OP_TICK: begin
        now_d = now_q + TIME_BITS'(1);
        if (active_q) begin
          consumed_d = pulse_out_ext[23:0];
          if (!online_q) begin
            if (left_q <= TIME_BITS'(1)) begin
              reason_d = STOP_TIMEOUT;
              active_d = 1'b0;
              online_d = 1'b0;
              budget_d = '0;
              pulse_d  = '0;
              left_d   = '0;
            end else begin
              left_d = left_q - TIME_BITS'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      online_q    <= 1'b0;
      budget_q    <= '0;
      pulse_q     <= '0;
      ovl_run_q   <= '0;
      full_run_q  <= '0;
      rpt_run_q   <= '0;
      now_q       <= '0;
      last_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        active_q   <= active_d;
        online_q   <= online_d;
        budget_q   <= budget_d;
        pulse_q    <= pulse_d;
        ovl_run_q  <= ovl_run_d;
        full_run_q <= full_run_d;
        rpt_run_q  <= rpt_run_d;
        now_q      <= now_d;
        last_q     <= last_d;
        left_q     <= left_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      relay_q    <= active_d;
      kind_q     <= kind_d;
      consumed_q <= consumed_d;
      reason_q   <= reason_d;
      cond_q     <= cond_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.relay_on    = relay_q;
  assign out_o.report_kind = kind_q;
  assign out_o.consumed    = consumed_q;
  assign out_o.stop_reason = reason_q;
  assign out_o.condition   = cond_q;

  // An idle port holds no session leftovers.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (pulse_q == '0 && left_q == '0 && budget_q == '0 && !online_q))
    else $error("idle port holds session state");

  // A progress report only comes from a running online session.
  a_progress_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == RPT_PROGRESS) |-> (relay_q && reason_q == STOP_NONE))
    else $error("progress report without a running session");

  // A stop always leaves the relay open.
  a_stop_opens_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && reason_q != STOP_NONE) |-> !relay_q)
    else $error("stop reported with relay closed");

  // Every item that leaves the input register produces a result next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no result");

  // A final report only comes with a stop command.
  a_final_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == RPT_FINAL) |-> (reason_q == STOP_CMD))
    else $error("final report without stop command");

endmodule

`default_nettype wire
